// ----- rtl/core/ptpr_pkg.sv -----
// ptpr_pkg: constants, types and the arctangent table for the point to polar filter
// no dependencies
`timescale 1ns / 1ps
package ptpr_pkg;
  localparam int CordicStagesDef = 16;
  localparam int CoordBitsDef    = 24;
  localparam int XyBits    = 35;   // guarded magnitude plus growth and sign
  localparam int ZBits     = 23;
  localparam int RadBits   = 25;
  localparam int AngBits   = 16;
  localparam int CfgIdxBits = 2;
  localparam int CfgDataBits = 25;
  localparam logic [CfgIdxBits-1:0] RegMaxRadius = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegMaxHeadRot = 2'd1;
  localparam logic [CfgIdxBits-1:0] RegCameraFov = 2'd2;
  localparam logic [RadBits-1:0] RadiusMax = 25'd23726566;
  localparam logic [23:0] InvGain = 24'd10188014;
  localparam logic signed [17:0] Deg180 = 18'sd23040;
  localparam logic signed [17:0] Deg360 = 18'sd46080;
  localparam logic signed [17:0] Deg90 = 18'sd11520;

  typedef struct packed {
    logic signed [CoordBitsDef-1:0] point_x;
    logic signed [CoordBitsDef-1:0] point_y;
    logic [1:0]                     point_kind;
    logic signed [CoordBitsDef-1:0] robot_x;
    logic signed [CoordBitsDef-1:0] robot_y;
    logic signed [AngBits-1:0]      robot_heading;
  } point_pose_t;

  typedef struct packed {
    logic [RadBits-1:0]        radius;
    logic signed [AngBits-1:0] bearing;
    logic [1:0]                kind_out;
    logic                      relevant;
  } polar_flag_t;

  typedef struct packed {
    logic signed [XyBits-1:0] x;
    logic signed [XyBits-1:0] y;
    logic signed [ZBits-1:0]  z;
    logic                     zero;
    logic                     neg_x;
    logic                     neg_y;
    logic signed [17:0]       head;
    logic [1:0]               kind;
  } cell_t;

  function automatic logic signed [ZBits-1:0] atan_lookup(input int i);
    logic signed [ZBits-1:0] r;
    case (i)
      0: r = 23'sd1474560;  1: r = 23'sd870484;  2: r = 23'sd459940;
      3: r = 23'sd233473;   4: r = 23'sd117189;  5: r = 23'sd58652;
      6: r = 23'sd29333;    7: r = 23'sd14667;   8: r = 23'sd7334;
      9: r = 23'sd3667;    10: r = 23'sd1833;   11: r = 23'sd917;
      12: r = 23'sd458;    13: r = 23'sd229;    14: r = 23'sd115;
      15: r = 23'sd57;     16: r = 23'sd29;     17: r = 23'sd14;
      18: r = 23'sd7;      19: r = 23'sd4;      20: r = 23'sd2;
      21: r = 23'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage

// ----- rtl/core/ptpr_stream_if.sv -----
// ptpr_stream_if: valid/ready channel with a generic payload type
// depends on nothing
`timescale 1ns / 1ps
interface ptpr_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/ptpr_cell.sv -----
// ptpr_cell: one cordic vectoring iteration, registered
// depends on ptpr_pkg
`timescale 1ns / 1ps
module ptpr_cell #(
  parameter int Shift = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  ptpr_pkg::cell_t  cell_i,
  output logic             valid_o,
  output ptpr_pkg::cell_t  cell_o
);
  logic            valid_q;
  ptpr_pkg::cell_t cell_q, cell_d;
  logic signed [ptpr_pkg::XyBits-1:0] xs, ys;
  localparam logic signed [ptpr_pkg::ZBits-1:0] Atan = ptpr_pkg::atan_lookup(Shift);

  always_comb begin
    xs = cell_i.x >>> Shift;
    ys = cell_i.y >>> Shift;
    cell_d = cell_i;
    if (!cell_i.y[ptpr_pkg::XyBits-1]) begin
      cell_d.x = cell_i.x + ys;
      cell_d.y = cell_i.y - xs;
      cell_d.z = cell_i.z + Atan;
    end else begin
      cell_d.x = cell_i.x - ys;
      cell_d.y = cell_i.y + xs;
      cell_d.z = cell_i.z - Atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (en_i) valid_q <= valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) cell_q <= cell_d;
  end
  assign valid_o = valid_q;
  assign cell_o = cell_q;
endmodule

// ----- rtl/core/point_to_polar_relevance_filter.sv -----
// point_to_polar_relevance_filter: top level, entry stage, cell chain and finishing stages
// depends on ptpr_pkg, ptpr_stream_if, ptpr_cell
`timescale 1ns / 1ps
// Takes one point and robot pose per transaction and returns radius, relative bearing,
// kind and a relevance flag. One transaction is accepted every cycle while the pipeline
// advances; the stages are an entry stage, one cell per cordic iteration, a stage for
// the gain multiply and angle placement, and the output register, which also takes the
// radius rounding and the limit test.
// The whole pipeline advances when the output register is empty or being taken.
module point_to_polar_relevance_filter #(
  parameter int CORDIC_STAGES = ptpr_pkg::CordicStagesDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [ptpr_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [ptpr_pkg::CfgDataBits-1:0] cfg_data_i,
  ptpr_stream_if.sink   in_if,
  ptpr_stream_if.source out_if
);
  localparam int COORD_BITS = ptpr_pkg::CoordBitsDef;
  localparam int GuardBits = 32 - COORD_BITS;

  logic [24:0] max_radius_q;
  logic [14:0] max_head_rot_q;
  logic [15:0] camera_fov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_radius_q   <= 25'd1280;
      max_head_rot_q <= 15'd11520;
      camera_fov_q   <= 16'd7680;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ptpr_pkg::RegMaxRadius:  max_radius_q <= cfg_data_i;
        ptpr_pkg::RegMaxHeadRot: max_head_rot_q <= cfg_data_i[14:0];
        ptpr_pkg::RegCameraFov:  camera_fov_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en = !out_if.valid || out_if.ready;
  assign in_if.ready = en;

  // entry stage: differences, magnitudes and heading clamp
  logic signed [COORD_BITS:0] dx, dy;
  logic [COORD_BITS:0] ax, ay;
  logic signed [17:0] hd;
  ptpr_pkg::cell_t c0_d;
  always_comb begin
    dx = $signed({in_if.data.point_x[COORD_BITS-1], in_if.data.point_x})
       - $signed({in_if.data.robot_x[COORD_BITS-1], in_if.data.robot_x});
    dy = $signed({in_if.data.point_y[COORD_BITS-1], in_if.data.point_y})
       - $signed({in_if.data.robot_y[COORD_BITS-1], in_if.data.robot_y});
    ax = dx[COORD_BITS] ? (COORD_BITS+1)'(0) - dx : dx;
    ay = dy[COORD_BITS] ? (COORD_BITS+1)'(0) - dy : dy;
    hd = 18'(in_if.data.robot_heading);
    if (hd > ptpr_pkg::Deg180) hd = ptpr_pkg::Deg180;
    if (hd < -ptpr_pkg::Deg180) hd = -ptpr_pkg::Deg180;
    c0_d.x = ptpr_pkg::XyBits'({ax, {GuardBits{1'b0}}});
    c0_d.y = ptpr_pkg::XyBits'({ay, {GuardBits{1'b0}}});
    c0_d.z = '0;
    c0_d.zero = (dx == '0) && (dy == '0);
    c0_d.neg_x = dx[COORD_BITS];
    c0_d.neg_y = dy[COORD_BITS];
    c0_d.head = hd;
    c0_d.kind = in_if.data.point_kind;
  end

  ptpr_pkg::cell_t chain [CORDIC_STAGES+1];
  logic            vchain [CORDIC_STAGES+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vchain[0] <= 1'b0;
    else if (en) vchain[0] <= in_if.valid;
  end
  always_ff @(posedge clk_i) begin
    if (en) chain[0] <= c0_d;
  end

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    ptpr_cell #(.Shift(g)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(vchain[g]), .cell_i(chain[g]),
      .valid_o(vchain[g+1]), .cell_o(chain[g+1])
    );
  end

  // finishing stage one: gain multiply, angle rounding and placement, heading subtraction
  ptpr_pkg::cell_t last;
  logic signed [ptpr_pkg::ZBits-1:0] zr;
  logic signed [17:0] a, ang, b;
  logic [ptpr_pkg::XyBits-2:0] xc;
  logic [57:0] prod;
  assign last = chain[CORDIC_STAGES];
  always_comb begin
    zr = (last.z + ptpr_pkg::ZBits'(128)) >>> 8;
    a = 18'(zr);
    if (zr < 0) a = '0;
    if (zr > ptpr_pkg::ZBits'(11520)) a = ptpr_pkg::Deg90;
    if (last.zero) a = '0;
    xc = last.x[ptpr_pkg::XyBits-1] ? '0 : last.x[ptpr_pkg::XyBits-2:0];
    if (!last.neg_x && !last.neg_y) ang = a;
    else if (last.neg_x && !last.neg_y) ang = ptpr_pkg::Deg180 - a;
    else if (last.neg_x) ang = ptpr_pkg::Deg180 + a;
    else ang = ptpr_pkg::Deg360 - a;
    b = ang - last.head;
    if (b > ptpr_pkg::Deg180) b = b - ptpr_pkg::Deg360;
    prod = 58'(xc) * 58'(ptpr_pkg::InvGain);
  end

  logic        v1_q;
  logic [57:0] prod_q;
  logic        zero_q;
  logic signed [17:0] b_q;
  logic [1:0]  kind1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= vchain[CORDIC_STAGES];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= prod; zero_q <= last.zero; b_q <= b; kind1_q <= last.kind;
    end
  end

  // finishing stage two: radius rounding, saturation and limit test
  logic [58:0] rsum;
  logic [32:0] rad_w;
  logic [24:0] rad;
  logic signed [19:0] lim2, b2;
  logic rel;
  always_comb begin
    rsum = 59'(prod_q) + (59'(1) << (23 + GuardBits));
    rad_w = 33'(rsum >> (24 + GuardBits));
    rad = (rad_w > 33'(ptpr_pkg::RadiusMax)) ? ptpr_pkg::RadiusMax : rad_w[24:0];
    if (zero_q) rad = '0;
    lim2 = $signed({4'b0, max_head_rot_q, 1'b0}) + $signed({4'b0, camera_fov_q});
    b2 = 20'(b_q) <<< 1;
    rel = (rad <= max_radius_q) && (b2 <= lim2) && (b2 >= -lim2);
  end

  logic out_v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_if.data.radius   <= rad;
      out_if.data.bearing  <= b_q[15:0];
      out_if.data.kind_out <= kind1_q;
      out_if.data.relevant <= rel;
    end
  end
  assign out_if.valid = out_v_q;
endmodule

// ----- rtl/core/ptpr_checker.sv -----
// ptpr_checker: port level checks for the point to polar filter, bound to the top level
// depends on point_to_polar_relevance_filter, through the bind
`timescale 1ns / 1ps
module ptpr_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [24:0] radius,
  input logic signed [15:0] bearing,
  input logic relevant
);
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(radius) && $stable(bearing))
    else $error("output changed while stalled");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready) else $error("input blocked with empty output");
  a_radius: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> radius <= 25'd23726566) else $error("radius out of range");
  a_bearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (bearing <= 16'sd23040) && (bearing >= -16'sd23040))
    else $error("bearing out of range");
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !$isunknown({radius, bearing, relevant}))
    else $error("unknown value on a valid transaction");
endmodule

bind point_to_polar_relevance_filter ptpr_checker u_ptpr_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .radius(out_if.data.radius), .bearing(out_if.data.bearing),
  .relevant(out_if.data.relevant)
);
